[hdl/hash_tag_crc32_slot_core_macros.svh]
// Assertion macros shared by the hash slot checker.
`ifndef HASH_TAG_CRC32_SLOT_CORE_MACROS_SVH
`define HASH_TAG_CRC32_SLOT_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define HTC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define HTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also watches reset itself.
`define HTC_ASSERT_NEXT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/htc_pkg.sv]
// Types, constants and the CRC byte step shared by the hash slot modules.
package htc_pkg;

   localparam logic [31:0] CrcSeed    = 32'hFFFF_FFFF;
   localparam logic [31:0] PolyReset  = 32'hEDB8_8320;
   localparam logic [7:0]  OpenBrace  = 8'h7B;
   localparam logic [7:0]  CloseBrace = 8'h7D;
   localparam int          QueueDepth = 4;
   localparam int          SlotWidth  = 10;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_IN   = 2'd1,
      PHASE_DONE = 2'd2
   } phase_type;

   // One classified key item on its way from front to back.
   typedef struct packed {
      logic       feed_whole;
      logic       feed_tag;
      logic [7:0] key_byte;
      logic       last;
      logic       use_tag;
   } item_type;

   // Reflected CRC update over one byte, LSB first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [7:0]  data,
                                            input logic [31:0] poly);
      logic [31:0] r;
      r = crc ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         if (r[0]) begin
            r = (r >> 1) ^ poly;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

endpackage

[hdl/htc_front.sv]
// Front end: accepts key bytes, tracks the braced tag and classifies each byte.
module htc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tuser,
   input  logic               req_tlast,
   input  logic               q_full,
   output logic               q_push,
   output htc_pkg::item_type  q_item
);

   htc_pkg::phase_type phase_ff, phase_in;
   logic               nonempty_ff, nonempty_in;
   logic               feed_tag;
   logic               accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Next state of the tag tracker.
   always_comb begin
      phase_in = phase_ff;
      if (req_tuser) begin
         case (phase_ff)
            htc_pkg::PHASE_IDLE: begin
               if (req_tdata == htc_pkg::OpenBrace) phase_in = htc_pkg::PHASE_IN;
            end
            htc_pkg::PHASE_IN: begin
               if (req_tdata == htc_pkg::CloseBrace) phase_in = htc_pkg::PHASE_DONE;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Outputs of the tag tracker.
   always_comb begin
      feed_tag = 1'b0;
      case (phase_ff)
         htc_pkg::PHASE_IN: feed_tag = req_tuser && (req_tdata != htc_pkg::CloseBrace);
         default:           feed_tag = 1'b0;
      endcase
      nonempty_in = nonempty_ff || feed_tag;
   end

   always_comb begin
      q_push            = accept;
      q_item.feed_whole = req_tuser;
      q_item.feed_tag   = feed_tag;
      q_item.key_byte   = req_tdata;
      q_item.last       = req_tlast;
      q_item.use_tag    = (phase_in == htc_pkg::PHASE_DONE) && nonempty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= htc_pkg::PHASE_IDLE;
         nonempty_ff <= 1'b0;
      end else if (accept) begin
         // Drop tag tracking at the end of each key.
         if (req_tlast) begin
            phase_ff    <= htc_pkg::PHASE_IDLE;
            nonempty_ff <= 1'b0;
         end else begin
            phase_ff    <= phase_in;
            nonempty_ff <= nonempty_in;
         end
      end
   end

endmodule

[hdl/htc_queue.sv]
// Short queue of classified items between front and back.
module htc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  htc_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output htc_pkg::item_type  head_item
);

   localparam int PtrWidth = $clog2(htc_pkg::QueueDepth);

   htc_pkg::item_type         entry_ff [htc_pkg::QueueDepth];
   logic [PtrWidth-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [PtrWidth:0]         count_ff, count_in;

   assign full       = (count_ff == (PtrWidth+1)'(htc_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

[hdl/htc_back.sv]
// Back end: runs both CRCs one byte per cycle unless a held result stalls it, and registers the slot result.
module htc_back #(
   parameter int SLOT_COUNT = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [31:0]                      crc_poly,
   input  logic                             head_valid,
   input  htc_pkg::item_type                head_item,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [htc_pkg::SlotWidth-1:0]    rsp_slot,
   output logic                             rsp_used_tag
);

   localparam logic [31:0] SlotMask = 32'(SLOT_COUNT - 1);

   logic [31:0]                   whole_ff, whole_in;
   logic [31:0]                   tag_ff, tag_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [htc_pkg::SlotWidth-1:0] slot_ff, slot_in;
   logic                          used_ff, used_in;
   logic [31:0]                   final_crc;

   // Non-final items never wait on the result register.
   assign pop = head_valid && (!head_item.last || !rsp_valid_ff || rsp_tready);

   always_comb begin
      whole_in = head_item.feed_whole ?
                 htc_pkg::crc_byte(whole_ff, head_item.key_byte, crc_poly) : whole_ff;
      tag_in   = head_item.feed_tag ?
                 htc_pkg::crc_byte(tag_ff, head_item.key_byte, crc_poly) : tag_ff;
      final_crc = ~(head_item.use_tag ? tag_in : whole_in);
      slot_in   = htc_pkg::SlotWidth'(final_crc & SlotMask);
      used_in   = head_item.use_tag;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (pop && head_item.last) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff     <= htc_pkg::CrcSeed;
         tag_ff       <= htc_pkg::CrcSeed;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (head_item.last) begin
               whole_ff <= htc_pkg::CrcSeed;
               tag_ff   <= htc_pkg::CrcSeed;
            end else begin
               whole_ff <= whole_in;
               tag_ff   <= tag_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_item.last) begin
         slot_ff <= slot_in;
         used_ff <= used_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_slot     = slot_ff;
   assign rsp_used_tag = used_ff;

endmodule

[hdl/hash_tag_crc32_slot_core.sv]
// Top level of the hash slot unit: CRC-32 over a key or its braced tag.
//
//   channel | direction | tdata               | tuser         | tlast
//   req     | in        | [7:0] key_byte      | [0] has_byte  | last
//   rsp     | out       | [9:0] slot, [15:10] 0 | [0] used_tag | -
//   csr     | in        | csr_wr_data: crc_poly, written when csr_wr_en is high
//
// One key byte is taken per cycle while req_tready is high; the back end runs one bytewise
// CRC step per cycle for each byte-carrying item, so a sustained stream moves at one item
// per cycle unless a held result stalls the back end. rsp_tvalid rises only after the last
// item of a key has passed through the queue and the result register. The four-entry queue
// between front and back absorbs output stalls; req_tready drops only when it is full.
// Synchronous reset seeds both CRCs, clears the tag tracker, sets crc_poly to the IEEE value.
module hash_tag_crc32_slot_core #(
   parameter int SLOT_COUNT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] key_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [9:0] slot, [15:10] zero
   output logic        rsp_tuser,   // [0] used_tag
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0]                   poly_ff;
   logic                          q_full, q_push, q_pop, q_head_valid;
   htc_pkg::item_type             q_item, q_head_item;
   logic [htc_pkg::SlotWidth-1:0] slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= htc_pkg::PolyReset;
      end else if (csr_wr_en) begin
         poly_ff <= csr_wr_data;
      end
   end

   htc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   htc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   htc_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .crc_poly     (poly_ff),
      .head_valid   (q_head_valid),
      .head_item    (q_head_item),
      .pop          (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_slot     (slot),
      .rsp_used_tag (rsp_tuser)
   );

   assign rsp_tdata = {(16 - htc_pkg::SlotWidth)'(0), slot};

endmodule

[hdl/htc_checker.sv]
// Port-level checker for the hash slot unit, bound to the top level.
`include "hash_tag_crc32_slot_core_macros.svh"

module htc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic [7:0] pending_ff;
   logic       key_done;
   logic       rsp_done;

   assign key_done = req_tvalid && req_tready && req_tlast;
   assign rsp_done = rsp_tvalid && rsp_tready;

   // Count keys closed on the input but not yet answered.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (key_done && !rsp_done) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (rsp_done && !key_done) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   `HTC_ASSERT_IMPL(a_rsp_has_key, rsp_done, pending_ff != 8'd0, "result without a closed key")
   `HTC_ASSERT_IMPL(a_pad_zero, rsp_tvalid, rsp_tdata[15:10] == 6'd0, "slot padding not zero")
   `HTC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `HTC_ASSERT_NEXT_RST(a_reset_idle, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind hash_tag_crc32_slot_core htc_checker u_checker (.*);
